/* hdl/alext_pkg.sv */
// ----------------------------------------------------------------------------
// alext_pkg: shared types, codes and saturating helpers
// Counter width, command and CIGAR codes, MD character codes, and the clamp
// functions that the accumulator and the result stages both use.
// ----------------------------------------------------------------------------
package alext_pkg;

  localparam int unsigned CW     = 32;  // accumulator width
  localparam int unsigned LEN_W  = 28;
  localparam int unsigned OP_W   = 4;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned OUT_W  = 32;

  // headroom so one add never wraps, whatever CW is in its range
  localparam int unsigned SUM_W = ((CW > LEN_W) ? CW : LEN_W) + 2;
  localparam int unsigned OW    = ((CW > OUT_W) ? CW : OUT_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CIGAR = 2'd0,
    CMD_MD    = 2'd1,
    CMD_END   = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  localparam logic [OP_W-1:0] OP_M = 4'd0;
  localparam logic [OP_W-1:0] OP_I = 4'd1;
  localparam logic [OP_W-1:0] OP_D = 4'd2;
  localparam logic [OP_W-1:0] OP_S = 4'd4;
  localparam logic [OP_W-1:0] OP_H = 4'd5;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;  // '^'

  // MD tag parse position
  typedef enum logic [2:0] {
    MD_START = 3'b001,  // tag start, letters not counted
    MD_COUNT = 3'b010,  // after a digit, letters are mismatches
    MD_DEL   = 3'b100   // after a caret, deleted bases
  } md_mode_e;

  typedef logic [CW-1:0]           cnt_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [OUT_W-1:0]        out_t;

  typedef struct packed {
    cnt_t match_acc;
    cnt_t mismatch_acc;
    cnt_t gap_open_acc;
    cnt_t gap_extend_acc;
    cnt_t read_length_acc;
    cnt_t clip_length_acc;
    cnt_t aligned_length_acc;
  } acc_t;

  // per-record snapshot travelling down the result pipe
  typedef struct packed {
    cnt_t match;
    cnt_t mismatch;
    cnt_t gap_open;
    cnt_t gap_extend;
    cnt_t read_length;
    cnt_t clip_length;
    cnt_t aligned_length;
    cnt_t edit_part;
  } stats_t;

  typedef struct packed {
    out_t match;
    out_t mismatch;
    out_t gap_open;
    out_t gap_extend;
    out_t read_length;
    out_t clip_length;
    out_t aligned_length;
    out_t edit_count;
  } res_t;

  localparam sum_t UMAX_X = {{(SUM_W-CW){1'b0}}, {CW{1'b1}}};
  localparam sum_t SMAX_X = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam sum_t SMIN_X = {{(SUM_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

  localparam logic [OW-1:0]        O_UMAX = {{(OW-OUT_W){1'b0}}, {OUT_W{1'b1}}};
  localparam logic signed [OW-1:0] O_SMAX = {{(OW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [OW-1:0] O_SMIN = {{(OW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  function automatic sum_t ext_u(cnt_t a);
    return {{(SUM_W-CW){1'b0}}, a};
  endfunction

  function automatic sum_t ext_s(cnt_t a);
    return {{(SUM_W-CW){a[CW-1]}}, a};
  endfunction

  function automatic sum_t ext_len(logic [LEN_W-1:0] a);
    return {{(SUM_W-LEN_W){1'b0}}, a};
  endfunction

  // clamp to [0, 2^CW-1]
  function automatic cnt_t sat_u(sum_t s);
    cnt_t r;
    if (s < 0) r = '0;
    else if (s > UMAX_X) r = '1;
    else r = s[CW-1:0];
    return r;
  endfunction

  // clamp to the two's complement range of CW bits
  function automatic cnt_t sat_s(sum_t s);
    cnt_t r;
    if (s > SMAX_X) r = SMAX_X[CW-1:0];
    else if (s < SMIN_X) r = SMIN_X[CW-1:0];
    else r = s[CW-1:0];
    return r;
  endfunction

  function automatic out_t out_u(cnt_t v);
    logic [OW-1:0] x;
    x = {{(OW-CW){1'b0}}, v};
    return (x > O_UMAX) ? '1 : x[OUT_W-1:0];
  endfunction

  function automatic out_t out_s(cnt_t v);
    logic signed [OW-1:0] x;
    out_t r;
    x = {{(OW-CW){v[CW-1]}}, v};
    if (x > O_SMAX) r = O_SMAX[OUT_W-1:0];
    else if (x < O_SMIN) r = O_SMIN[OUT_W-1:0];
    else r = x[OUT_W-1:0];
    return r;
  endfunction

endpackage

/* hdl/alignment_extended_summary.sv */
// ----------------------------------------------------------------------------
// alignment_extended_summary: per-record alignment statistics
// Accumulates CIGAR and MD-tag beats of one alignment record and returns the
// match, mismatch, gap, length, clip and edit counts on the end beat.
// ----------------------------------------------------------------------------
// One input beat is taken every clock cycle unless an end beat waits for a
// free snapshot register; each CIGAR or MD beat is decoded and added into
// the saturating counters in the cycle after it is taken, so the accumulator
// update from the input register sets the rate. An end beat's result goes
// through a snapshot register and a two-stage finish pipe, with the counters
// already cleared for the next record; CIGAR, MD and no-operation beats give
// no result. Results back up through these registers before the input stalls.
module alignment_extended_summary (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [alext_pkg::CMD_W-1:0]   command_i,
  input  logic [alext_pkg::OP_W-1:0]    cigar_op_i,
  input  logic [alext_pkg::LEN_W-1:0]   op_length_i,
  input  logic [alext_pkg::CHAR_W-1:0]  md_char_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [alext_pkg::OUT_W-1:0] match_o,
  output logic [alext_pkg::OUT_W-1:0]   mismatch_o,
  output logic [alext_pkg::OUT_W-1:0]   gap_open_o,
  output logic signed [alext_pkg::OUT_W-1:0] gap_extend_o,
  output logic [alext_pkg::OUT_W-1:0]   read_length_o,
  output logic [alext_pkg::OUT_W-1:0]   clip_length_o,
  output logic [alext_pkg::OUT_W-1:0]   aligned_length_o,
  output logic [alext_pkg::OUT_W-1:0]   edit_count_o
);
  import alext_pkg::*;

  logic    snap_valid, snap_ready;
  stats_t  snap;
  res_t    res;

  alext_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .cigar_op_i   (cigar_op_i),
    .op_length_i  (op_length_i),
    .md_char_i    (md_char_i),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  alext_finish u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign match_o          = res.match;
  assign mismatch_o       = res.mismatch;
  assign gap_open_o       = res.gap_open;
  assign gap_extend_o     = res.gap_extend;
  assign read_length_o    = res.read_length;
  assign clip_length_o    = res.clip_length;
  assign aligned_length_o = res.aligned_length;
  assign edit_count_o     = res.edit_count;

endmodule

/* hdl/alext_accum.sv */
// ----------------------------------------------------------------------------
// alext_accum: input register and record accumulators
// Decodes CIGAR and MD beats from the input register into the saturating
// counters; an end beat snapshots the counters and clears them.
// ----------------------------------------------------------------------------
module alext_accum (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [alext_pkg::CMD_W-1:0]    command_i,
  input  logic [alext_pkg::OP_W-1:0]     cigar_op_i,
  input  logic [alext_pkg::LEN_W-1:0]    op_length_i,
  input  logic [alext_pkg::CHAR_W-1:0]   md_char_i,
  output logic                           snap_valid_o,
  input  logic                           snap_ready_i,
  output alext_pkg::stats_t              snap_o
);
  import alext_pkg::*;

  logic               a_valid_q, a_valid_d;
  cmd_e               a_cmd_q;
  logic [OP_W-1:0]    a_op_q;
  logic [LEN_W-1:0]   a_len_q;
  logic [CHAR_W-1:0]  a_char_q;

  acc_t               acc_q, acc_d;
  md_mode_e           md_q, md_d;

  logic               snap_valid_q, snap_valid_d;
  stats_t             snap_q, snap_d;

  logic               is_end, snap_free, a_fire, in_fire;
  sum_t               len_x;

  assign is_end     = (a_cmd_q == CMD_END);
  assign snap_free  = !snap_valid_q || snap_ready_i;
  assign a_fire     = a_valid_q && (!is_end || snap_free);
  assign in_ready_o = !a_valid_q || a_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign len_x      = ext_len(a_len_q);

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_fire) a_valid_d = 1'b1;
    else if (a_fire) a_valid_d = 1'b0;
  end

  always_comb begin
    acc_d = acc_q;
    md_d  = md_q;
    if (a_fire) begin
      unique case (a_cmd_q)
        CMD_CIGAR: begin
          case (a_op_q) inside
            OP_M: begin
              acc_d.match_acc          = sat_s(ext_s(acc_q.match_acc) + len_x);
              acc_d.read_length_acc    = sat_u(ext_u(acc_q.read_length_acc) + len_x);
              acc_d.aligned_length_acc = sat_u(ext_u(acc_q.aligned_length_acc) + len_x);
            end
            OP_I, OP_D: begin
              if (a_op_q == OP_I) begin
                acc_d.read_length_acc = sat_u(ext_u(acc_q.read_length_acc) + len_x);
              end
              acc_d.gap_open_acc       = sat_u(ext_u(acc_q.gap_open_acc) + sum_t'(1));
              acc_d.gap_extend_acc     = sat_s(ext_s(acc_q.gap_extend_acc) + len_x
                                               - sum_t'(1));
              acc_d.aligned_length_acc = sat_u(ext_u(acc_q.aligned_length_acc) + len_x);
            end
            OP_S, OP_H: begin
              acc_d.clip_length_acc = sat_u(ext_u(acc_q.clip_length_acc) + len_x);
              acc_d.read_length_acc = sat_u(ext_u(acc_q.read_length_acc) + len_x);
            end
            default: ;
          endcase
        end
        CMD_MD: begin
          if (a_char_q != CH_NUL) begin
            if (a_char_q >= CH_ZERO && a_char_q <= CH_NINE) begin
              md_d = MD_COUNT;
            end else if (a_char_q == CH_CARET) begin
              md_d = MD_DEL;
            end else if (md_q == MD_COUNT) begin
              acc_d.mismatch_acc = sat_u(ext_u(acc_q.mismatch_acc) + sum_t'(1));
            end
          end
        end
        CMD_END: begin
          acc_d = '0;
          md_d  = MD_START;
        end
        default: ;
      endcase
    end
  end

  // snapshot taken from the counters as they stand before the end beat
  always_comb begin
    snap_d.match          = sat_s(ext_s(acc_q.match_acc) - ext_u(acc_q.mismatch_acc));
    snap_d.mismatch       = acc_q.mismatch_acc;
    snap_d.gap_open       = acc_q.gap_open_acc;
    snap_d.gap_extend     = acc_q.gap_extend_acc;
    snap_d.read_length    = acc_q.read_length_acc;
    snap_d.clip_length    = acc_q.clip_length_acc;
    snap_d.aligned_length = acc_q.aligned_length_acc;
    snap_d.edit_part      = sat_u(ext_u(acc_q.mismatch_acc) + ext_u(acc_q.clip_length_acc));
  end

  always_comb begin
    snap_valid_d = snap_valid_q;
    if (a_fire && is_end) snap_valid_d = 1'b1;
    else if (snap_ready_i) snap_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q    <= 1'b0;
      acc_q        <= '0;
      md_q         <= MD_START;
      snap_valid_q <= 1'b0;
    end else begin
      a_valid_q    <= a_valid_d;
      acc_q        <= acc_d;
      md_q         <= md_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_cmd_q  <= cmd_e'(command_i);
      a_op_q   <= cigar_op_i;
      a_len_q  <= op_length_i;
      a_char_q <= md_char_i;
    end
    if (a_fire && is_end) snap_q <= snap_d;
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_fire && is_end) |=> (acc_q == '0 && md_q == MD_START))
    else $error("counters not cleared after end beat");

  a_end_snaps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_fire && is_end) |=> snap_valid_q)
    else $error("end beat produced no snapshot");

  a_mismatch_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_fire && !is_end) |=> (acc_q.mismatch_acc >= $past(acc_q.mismatch_acc)))
    else $error("mismatch count went down within a record");

  a_hold_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && is_end && !snap_free) |=> (a_valid_q && is_end))
    else $error("stalled end beat dropped");

endmodule

/* hdl/alext_finish.sv */
// ----------------------------------------------------------------------------
// alext_finish: edit count and result register
// Completes the saturating edit-count sum over two stages and clamps every
// field to its 32-bit output range.
// ----------------------------------------------------------------------------
module alext_finish (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               snap_valid_i,
  output logic               snap_ready_o,
  input  alext_pkg::stats_t  snap_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output alext_pkg::res_t    res_o
);
  import alext_pkg::*;

  logic    c_valid_q, c_valid_d;
  stats_t  c_q, c_d;
  logic    out_valid_q, out_valid_d;
  res_t    res_q, res_d;
  logic    out_free, c_free, c_load, o_load;

  assign out_free     = !out_valid_q || out_ready_i;
  assign c_free       = !c_valid_q || out_free;
  assign snap_ready_o = c_free;
  assign c_load       = snap_valid_i && c_free;
  assign o_load       = c_valid_q && out_free;

  always_comb begin
    c_d           = snap_i;
    c_d.edit_part = sat_u(ext_u(snap_i.edit_part) + ext_u(snap_i.gap_open));
  end

  // negative gap extension pulls the sum down, clamped at zero
  always_comb begin
    res_d.match          = out_s(c_q.match);
    res_d.mismatch       = out_u(c_q.mismatch);
    res_d.gap_open       = out_u(c_q.gap_open);
    res_d.gap_extend     = out_s(c_q.gap_extend);
    res_d.read_length    = out_u(c_q.read_length);
    res_d.clip_length    = out_u(c_q.clip_length);
    res_d.aligned_length = out_u(c_q.aligned_length);
    res_d.edit_count     = out_u(sat_u(ext_u(c_q.edit_part) + ext_s(c_q.gap_extend)));
  end

  always_comb begin
    c_valid_d = c_valid_q;
    if (c_load) c_valid_d = 1'b1;
    else if (o_load) c_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (o_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      c_valid_q   <= c_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_load) c_q <= c_d;
    if (o_load) res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
